@@ rtl/core/lts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;

    localparam int DIV_BITS = 48;
    localparam int CMP_BITS = 8;

    localparam logic [1:0] MODE_LU   = 2'd0;
    localparam logic [1:0] MODE_PERM = 2'd1;
    localparam logic [1:0] MODE_RHS  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_FPERM, S_FRHS, S_FLOAD, S_RD, S_MUL, S_ACC, S_FWRITE,
        S_BSTART, S_BLOAD, S_DIV, S_DWAIT, S_BWRITE, S_ORD, S_OSHOW
    } t_state;

    // one restoring-division step: remainder, dividend bits shifting out
    // while quotient bits shift in, divisor magnitude, result sign
    typedef struct packed {
        logic [31:0]         rem;
        logic [DIV_BITS-1:0] nq;
        logic [31:0]         den;
        logic                neg;
    } t_div;

endpackage
`default_nettype wire

@@ rtl/core/lu_triangular_solve.sv @@
`timescale 1ns / 1ps
`default_nettype none
// LU forward/backward substitution, Q16.16.
// Input channel (i_in_valid / o_in_stall) carries load words: mode 0 writes a
// packed LU entry, mode 1 a permutation entry, mode 2 a right-hand-side element.
// The rhs word at row n-1 starts a solve; n comes from the order register,
// written through i_cfg_wr_en / i_cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Load words
// are accepted back to back while idle. Each multiply-accumulate step runs on
// the single multiplier; each backward row with a nonzero pivot waits on the
// 48-cell restoring divider chain. The n solution words then leave in turn on
// o_out_valid / i_out_stall; o_in_stall stays high from the start of the solve
// until the last solution word is taken. A stalled solution word holds.
// Reset sets the order to 16 and returns to idle; stores keep no reset value.
module lu_triangular_solve #(
    parameter int MAX_ORDER  = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire        [4:0]  i_cfg_wr_data,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire        [1:0]  i_mode,
    input  wire        [3:0]  i_row,
    input  wire        [3:0]  i_col,
    input  wire signed [31:0] i_value,
    input  wire        [3:0]  i_source_row,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [31:0] o_solution_value,
    output logic       [3:0]  o_solution_row,
    output logic              o_last,
    output logic              o_overflow,
    output logic              o_zero_pivot
);
    import lts_pkg::*;

    localparam int IW        = $clog2(MAX_ORDER);
    localparam int FAW       = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int ORDER_CAP = (MAX_ORDER < 16) ? MAX_ORDER : 16;
    localparam int SAT_BITS  = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam logic signed [48:0] SAT_HI = (49'sd1 <<< (SAT_BITS - 1)) - 49'sd1;
    localparam logic signed [48:0] SAT_LO = -SAT_HI - 49'sd1;

    logic signed [31:0] fac_mem  [MAX_ORDER*MAX_ORDER];
    logic        [3:0]  perm_mem [MAX_ORDER];
    logic signed [31:0] rhs_mem  [MAX_ORDER];
    logic signed [31:0] work_mem [MAX_ORDER];

    t_state r_state, n_state;
    logic [4:0]    r_msize, n_msize;
    logic [IW-1:0] r_i, n_i, r_k, n_k;
    logic          r_bwd, n_bwd, r_ovf, n_ovf, r_piv, n_piv, r_src_ok;
    logic [5:0]    r_cnt, n_cnt;
    logic signed [31:0] r_acc, n_acc, r_u, n_u, r_res, n_res;
    logic signed [31:0] r_fdata, r_wdata, r_rdata;
    logic [3:0]    r_pdata;
    logic signed [63:0] r_prod;

    logic [4:0]    order_n;
    logic [IW-1:0] last_i;
    logic          accept_in, row_ok, col_ok;
    logic [FAW-1:0] fac_wr_addr, fac_rd_addr;
    logic [IW-1:0] work_rd_addr;
    logic          work_we;
    logic signed [31:0] work_wr_data;
    logic signed [63:0] rnd;
    logic signed [48:0] diff;
    logic signed [31:0] acc_sat;
    logic          acc_ovf;
    logic signed [31:0] div_quo;
    logic          div_ovf;

    always_comb begin
        if (r_msize == 5'd0)
            order_n = 5'd1;
        else if (CMP_BITS'(r_msize) > CMP_BITS'(ORDER_CAP))
            order_n = 5'(ORDER_CAP);
        else
            order_n = r_msize;
        last_i = IW'(order_n - 5'd1);
    end

    assign accept_in = i_in_valid && !o_in_stall;
    assign row_ok = CMP_BITS'(i_row) < CMP_BITS'(MAX_ORDER);
    assign col_ok = CMP_BITS'(i_col) < CMP_BITS'(MAX_ORDER);
    assign fac_wr_addr = FAW'(FAW'(i_row) * FAW'(MAX_ORDER) + FAW'(i_col));

    always_comb begin
        if (r_state == S_BSTART)
            fac_rd_addr = FAW'(FAW'(r_i) * FAW'(MAX_ORDER) + FAW'(r_i));
        else
            fac_rd_addr = FAW'(FAW'(r_i) * FAW'(MAX_ORDER) + FAW'(r_k));
        if (r_state == S_BSTART || r_state == S_ORD || r_state == S_OSHOW)
            work_rd_addr = r_i;
        else
            work_rd_addr = r_k;
        work_we      = r_state == S_FWRITE || r_state == S_BWRITE;
        work_wr_data = (r_state == S_FWRITE) ? r_acc : r_res;
    end

    // load stores
    always_ff @(posedge i_clk) begin
        if (accept_in && row_ok) begin
            if (i_mode == MODE_LU && col_ok)
                fac_mem[fac_wr_addr] <= i_value;
            if (i_mode == MODE_PERM)
                perm_mem[IW'(i_row)] <= i_source_row;
            if (i_mode == MODE_RHS)
                rhs_mem[IW'(i_row)] <= i_value;
        end
        r_fdata <= fac_mem[fac_rd_addr];
        r_pdata <= perm_mem[r_i];
        r_rdata <= rhs_mem[IW'(r_pdata)];
        r_src_ok <= CMP_BITS'(r_pdata) < CMP_BITS'(order_n);
    end

    always_ff @(posedge i_clk) begin
        if (work_we)
            work_mem[r_i] <= work_wr_data;
        r_wdata <= work_mem[work_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(r_fdata) * 64'(r_wdata);
    end

    // round to Q16.16 (floor after adding half), subtract, saturate
    always_comb begin
        rnd  = (r_prod + 64'sd32768) >>> 16;
        diff = 49'(r_acc) - rnd[48:0];
        acc_ovf = 1'b0;
        if (diff > SAT_HI) begin
            acc_sat = 32'(SAT_HI);
            acc_ovf = 1'b1;
        end else if (diff < SAT_LO) begin
            acc_sat = 32'(SAT_LO);
            acc_ovf = 1'b1;
        end else begin
            acc_sat = 32'(diff);
        end
    end

    lts_divider #(.SAT_BITS(SAT_BITS)) u_div (
        .i_clk (i_clk),
        .i_num (r_acc),
        .i_den (r_u),
        .o_quo (div_quo),
        .o_ovf (div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msize <= 5'd16;
            r_i     <= '0;
            r_k     <= '0;
            r_bwd   <= 1'b0;
            r_ovf   <= 1'b0;
            r_piv   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_msize <= n_msize;
            r_i     <= n_i;
            r_k     <= n_k;
            r_bwd   <= n_bwd;
            r_ovf   <= n_ovf;
            r_piv   <= n_piv;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_u   <= n_u;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_msize = i_cfg_wr_en ? i_cfg_wr_data : r_msize;
        n_i   = r_i;
        n_k   = r_k;
        n_bwd = r_bwd;
        n_ovf = r_ovf;
        n_piv = r_piv;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_u   = r_u;
        n_res = r_res;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_mode == MODE_RHS && row_ok
                        && {1'b0, i_row} == 5'(order_n - 5'd1)) begin
                    n_i     = '0;
                    n_bwd   = 1'b0;
                    n_ovf   = 1'b0;
                    n_piv   = 1'b0;
                    n_state = S_FPERM;
                end
            end
            S_FPERM: n_state = S_FRHS;
            S_FRHS:  n_state = S_FLOAD;
            S_FLOAD: begin
                n_acc   = r_src_ok ? r_rdata : 32'sd0;
                n_k     = '0;
                n_state = (r_i == '0) ? S_FWRITE : S_RD;
            end
            S_RD:  n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                n_acc = acc_sat;
                n_ovf = r_ovf | acc_ovf;
                if (!r_bwd) begin
                    if (IW'(r_k + 1'b1) == r_i) n_state = S_FWRITE;
                    else begin
                        n_k     = IW'(r_k + 1'b1);
                        n_state = S_RD;
                    end
                end else begin
                    if (IW'(r_k - 1'b1) == r_i) n_state = S_DIV;
                    else begin
                        n_k     = IW'(r_k - 1'b1);
                        n_state = S_RD;
                    end
                end
            end
            S_FWRITE: begin
                if (r_i == last_i) begin
                    n_bwd   = 1'b1;
                    n_state = S_BSTART;
                end else begin
                    n_i     = IW'(r_i + 1'b1);
                    n_state = S_FPERM;
                end
            end
            S_BSTART: n_state = S_BLOAD;
            S_BLOAD: begin
                n_acc   = r_wdata;
                n_u     = r_fdata;
                n_k     = last_i;
                n_state = (r_i == last_i) ? S_DIV : S_RD;
            end
            S_DIV: begin
                if (r_u == 32'sd0) begin
                    n_piv   = 1'b1;
                    n_res   = 32'sd0;
                    n_state = S_BWRITE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                n_cnt = 6'(r_cnt + 1'b1);
                if (r_cnt == 6'(DIV_BITS)) begin
                    n_res   = div_quo;
                    n_ovf   = r_ovf | div_ovf;
                    n_state = S_BWRITE;
                end
            end
            S_BWRITE: begin
                if (r_i == '0) n_state = S_ORD;
                else begin
                    n_i     = IW'(r_i - 1'b1);
                    n_state = S_BSTART;
                end
            end
            S_ORD: n_state = S_OSHOW;
            S_OSHOW: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_i == last_i) n_state = S_IDLE;
                    else begin
                        n_i     = IW'(r_i + 1'b1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_solution_value = r_wdata;
    assign o_solution_row   = 4'(r_i);
    assign o_last           = r_i == last_i;
    assign o_overflow       = r_ovf;
    assign o_zero_pivot     = r_piv;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while solution word pending");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after last solution word");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT) |-> (r_cnt <= 6'(DIV_BITS)))
        else $error("divider wait overran");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_solution_row} < order_n))
        else $error("solution row beyond order");
endmodule
`default_nettype wire

@@ rtl/core/lts_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lts_div_cell (
    input  wire          i_clk,
    input  wire lts_pkg::t_div i_div,
    output lts_pkg::t_div o_div
);
    import lts_pkg::*;

    logic [32:0] trial;
    logic        fits;
    t_div        n_div;
    t_div        r_div;

    always_comb begin
        trial = {i_div.rem, i_div.nq[DIV_BITS-1]};
        fits  = trial >= {1'b0, i_div.den};
        n_div = i_div;
        n_div.rem = fits ? 32'(trial - {1'b0, i_div.den}) : trial[31:0];
        n_div.nq  = {i_div.nq[DIV_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_div = r_div;
endmodule
`default_nettype wire

@@ rtl/core/lts_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lts_divider #(
    parameter int SAT_BITS = 32
) (
    input  wire               i_clk,
    input  wire signed [31:0] i_num,
    input  wire signed [31:0] i_den,
    output logic signed [31:0] o_quo,
    output logic              o_ovf
);
    import lts_pkg::*;

    localparam logic signed [48:0] SAT_HI = (49'sd1 <<< (SAT_BITS - 1)) - 49'sd1;
    localparam logic signed [48:0] SAT_LO = -SAT_HI - 49'sd1;

    t_div chain [DIV_BITS+1];
    logic [31:0] abs_num;
    logic [31:0] abs_den;
    logic signed [48:0] quo;

    always_comb begin
        abs_num = i_num[31] ? 32'(-i_num) : 32'(i_num);
        abs_den = i_den[31] ? 32'(-i_den) : 32'(i_den);
        chain[0].rem = '0;
        chain[0].nq  = {abs_num, 16'd0};
        chain[0].den = abs_den;
        chain[0].neg = i_num[31] ^ i_den[31];
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
        lts_div_cell u_cell (
            .i_clk (i_clk),
            .i_div (chain[g]),
            .o_div (chain[g+1])
        );
    end

    always_comb begin
        quo = chain[DIV_BITS].neg ? -$signed({1'b0, chain[DIV_BITS].nq})
                                  : $signed({1'b0, chain[DIV_BITS].nq});
        o_ovf = 1'b0;
        if (quo > SAT_HI) begin
            o_quo = 32'(SAT_HI);
            o_ovf = 1'b1;
        end else if (quo < SAT_LO) begin
            o_quo = 32'(SAT_LO);
            o_ovf = 1'b1;
        end else begin
            o_quo = 32'(quo);
        end
    end
endmodule
`default_nettype wire

@@ sim/lts_checker.sv @@
`timescale 1ns / 1ps
module lts_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire        [4:0]  i_cfg_wr_data,
    input  wire               i_in_valid,
    input  wire               i_in_stall,
    input  wire        [1:0]  i_mode,
    input  wire        [3:0]  i_row,
    input  wire        [3:0]  i_col,
    input  wire signed [31:0] i_value,
    input  wire        [3:0]  i_source_row,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  wire signed [31:0] i_solution_value,
    input  wire        [3:0]  i_solution_row,
    input  wire               i_last,
    input  wire               i_overflow,
    input  wire               i_zero_pivot,
    output int                o_pending,
    output int                o_errors
);
    import lts_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         row;
        logic               last;
        logic               overflow;
        logic               zero_pivot;
    } t_solution;

    t_solution   solution_q[$];
    logic [4:0]  order_reg;
    longint      factor_mem[16][16];
    logic [3:0]  perm_mem[16];
    longint      rhs_mem[16];
    longint      work_mem[16];
    bit          sat_seen;
    bit          pivot_seen;

    initial begin
        o_pending = 0;
        o_errors  = 0;
        order_reg = 5'd16;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: solution mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_errors++;
    endtask

    function automatic longint clip(input longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 product, rounded half up (floor after adding 0.5 lsb)
    function automatic longint qmul(input longint a, input longint b);
        longint t;
        t = a * b + 64'sd32768;
        return t >>> 16;
    endfunction

    task automatic solve_column(input int n);
        longint    z;
        longint    u;
        int        src;
        t_solution s;
        sat_seen   = 1'b0;
        pivot_seen = 1'b0;
        for (int i = 0; i < n; i++) begin
            src = perm_mem[i];
            z = (src < n) ? rhs_mem[src] : 0;
            for (int k = 0; k < i; k++)
                z = clip(z - qmul(factor_mem[i][k], work_mem[k]));
            work_mem[i] = z;
        end
        for (int i = n - 1; i >= 0; i--) begin
            z = work_mem[i];
            u = factor_mem[i][i];
            for (int k = n - 1; k > i; k--)
                z = clip(z - qmul(factor_mem[i][k], work_mem[k]));
            if (u == 0) begin
                pivot_seen = 1'b1;
                z = 0;
            end else begin
                z = clip((z * 64'sd65536) / u);
            end
            work_mem[i] = z;
        end
        for (int i = 0; i < n; i++) begin
            s.value      = work_mem[i][31:0];
            s.row        = i[3:0];
            s.last       = (i == n - 1);
            s.overflow   = sat_seen;
            s.zero_pivot = pivot_seen;
            solution_q.push_back(s);
        end
    endtask

    always @(posedge i_clk) begin
        int        n;
        t_solution s;
        if (!i_rst_n) begin
            order_reg = 5'd16;
            solution_q.delete();
        end else begin
            if (i_cfg_wr_en)
                order_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                n = (order_reg < 1) ? 1 : (order_reg > 16) ? 16 : order_reg;
                case (i_mode)
                    MODE_LU: factor_mem[i_row][i_col] = i_value;
                    MODE_PERM: perm_mem[i_row] = i_source_row;
                    MODE_RHS: begin
                        rhs_mem[i_row] = i_value;
                        if (i_row == n - 1)
                            solve_column(n);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (solution_q.size() == 0) begin
                    report("unexpected word", i_solution_value, 0);
                end else begin
                    s = solution_q.pop_front();
                    if (i_solution_value !== s.value)
                        report("value", i_solution_value, s.value);
                    if (i_solution_row !== s.row)
                        report("row", i_solution_row, s.row);
                    if (i_last !== s.last)
                        report("last", i_last, s.last);
                    if (i_overflow !== s.overflow)
                        report("overflow", i_overflow, s.overflow);
                    if (i_zero_pivot !== s.zero_pivot)
                        report("zero_pivot", i_zero_pivot, s.zero_pivot);
                end
            end
        end
        o_pending = solution_q.size();
    end

endmodule

@@ sim/lu_triangular_solve_tb.sv @@
`timescale 1ns / 1ps
module lu_triangular_solve_tb;
    import lts_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic        [4:0]  cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic        [1:0]  in_mode = '0;
    logic        [3:0]  in_row = '0;
    logic        [3:0]  in_col = '0;
    logic signed [31:0] in_value = '0;
    logic        [3:0]  in_source = '0;
    logic               out_stall = 1'b0;
    wire                in_stall;
    wire                out_valid;
    wire signed  [31:0] sol_value;
    wire         [3:0]  sol_row;
    wire                sol_last;
    wire                sol_ovf;
    wire                sol_piv;
    int                 pending;
    int                 errors;

    bit   quiet = 1'b0;
    int   stall_left = 0;
    int   words_sent = 0;
    int   order_now = 16;
    bit   lu_ok[16][16];
    bit   perm_ok[16];
    bit   rhs_ok[16];
    int   perm_src[16];

    lu_triangular_solve u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(in_mode), .i_row(in_row), .i_col(in_col),
        .i_value(in_value), .i_source_row(in_source),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_solution_value(sol_value), .o_solution_row(sol_row),
        .o_last(sol_last), .o_overflow(sol_ovf), .o_zero_pivot(sol_piv)
    );

    lts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_mode(in_mode), .i_row(in_row), .i_col(in_col),
        .i_value(in_value), .i_source_row(in_source),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_solution_value(sol_value), .i_solution_row(sol_row),
        .i_last(sol_last), .i_overflow(sol_ovf), .i_zero_pivot(sol_piv),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure in bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            2: return 32'h0001_0000 + $urandom_range(0, 1 << 15);
            3: return '0;
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        endcase
    endfunction

    task automatic send_word(input logic [1:0] mode, input int row, input int col,
                             input logic [31:0] value, input int src);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_mode   <= mode;
        in_row    <= row[3:0];
        in_col    <= col[3:0];
        in_value  <= value;
        in_source <= src[3:0];
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic put_lu(input int r, input int c, input logic [31:0] v);
        send_word(MODE_LU, r, c, v, $urandom_range(0, 15));
        lu_ok[r][c] = 1'b1;
    endtask

    task automatic put_perm(input int r, input int s);
        send_word(MODE_PERM, r, $urandom_range(0, 15), $urandom, s);
        perm_ok[r]  = 1'b1;
        perm_src[r] = s;
    endtask

    task automatic put_rhs(input int r, input logic [31:0] v);
        send_word(MODE_RHS, r, $urandom_range(0, 15), v, $urandom_range(0, 15));
        rhs_ok[r] = 1'b1;
    endtask

    // make sure the solve only reads entries already written, then start it
    task automatic run_column(input logic [31:0] last_rhs);
        int n;
        n = order_now;
        for (int i = 0; i < n; i++)
            for (int k = 0; k < n; k++)
                if (!lu_ok[i][k])
                    put_lu(i, k, (i == k) ? 32'h0001_0000 + $urandom_range(0, 1 << 16)
                                          : pick_value());
        for (int i = 0; i < n; i++)
            if (!perm_ok[i]) put_perm(i, $urandom_range(0, n - 1));
        for (int i = 0; i < n; i++)
            if (perm_src[i] < n - 1 && !rhs_ok[perm_src[i]])
                put_rhs(perm_src[i], pick_value());
        put_rhs(n - 1, last_rhs);
    endtask

    // order register is only touched once the block has drained
    task automatic set_order(input logic [4:0] v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        order_now = (v < 1) ? 1 : (v > 16) ? 16 : v;
    endtask

    task automatic random_phase(input int words);
        int n;
        int r;
        n = order_now;
        for (int w = 0; w < words; w++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    if ($urandom_range(0, 5) == 0)
                        put_lu($urandom_range(0, 15), $urandom_range(0, 15), pick_value());
                    else
                        put_lu($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               pick_value());
                end
                9, 10, 11: put_perm($urandom_range(0, 15),
                                    $urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                               : $urandom_range(0, n - 1));
                12, 13, 14: begin
                    r = $urandom_range(0, 15);
                    if (r != n - 1) put_rhs(r, pick_value());
                end
                15: send_word(MODE_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom, $urandom_range(0, 15));
                default: run_column(pick_value());
            endcase
        end
        run_column(pick_value());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // order 0 clamps to 1: identity, zero pivot, tiny pivot overflow
        set_order(5'd0);
        put_lu(0, 0, 32'h0001_0000);
        put_perm(0, 0);
        run_column(32'h7FFF_FFFF);
        put_lu(0, 0, 32'h0000_0000);
        run_column(32'h0003_0000);
        send_word(MODE_NONE, 0, 0, 32'hFFFF_FFFF, 15);
        put_lu(0, 0, 32'h0000_0001);
        run_column(32'h8000_0000);

        // order 2: out-of-range permutation source, rhs at a row other than n-1
        set_order(5'd2);
        put_lu(0, 0, 32'h0001_0000);
        put_lu(1, 1, 32'hFFFF_0000);
        put_lu(1, 0, 32'h7FFF_FFFF);
        put_lu(0, 1, 32'h8000_0000);
        put_perm(0, 15);
        put_perm(1, 0);
        put_rhs(0, 32'h0002_8000);
        run_column(32'h0001_0000);
        put_lu(15, 15, 32'hA5A5_5A5A);
        put_perm(15, 15);
        put_rhs(15, 32'h5A5A_A5A5);
        run_column(32'h7FFF_0000);

        // random phases over small orders
        while (words_sent < 110) begin
            set_order($urandom_range(1, 5));
            random_phase($urandom_range(4, 16));
        end

        quiet = 1'b1;
        while (words_sent < 220) begin
            set_order($urandom_range(1, 4));
            random_phase($urandom_range(4, 12));
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lts_pkg.sv
rtl/core/lts_div_cell.sv
rtl/core/lts_divider.sv
rtl/core/lu_triangular_solve.sv
sim/lts_checker.sv
sim/lu_triangular_solve_tb.sv
